// File: hdl/rli_pkg.sv
package rli_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed port field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

endpackage

// File: hdl/ranked_list_insert_remove_top.sv
// Ranked list store: ordered list of up to CAPACITY words in one RAM plus a count.
// Read, write and refused operations go straight to the result state; insert moves the
// entries at or after the position up by one through the shift state when any exist, then
// writes the new word; remove moves the entries after the clipped end down when any exist.
// One operation in flight; a shift moves one entry per cycle through the single RAM port pair.
// Reset (async, active low) empties the list; RAM contents stay undefined, no clearing pass.
module ranked_list_insert_remove_top
    import rli_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [POS_W-1:0]  position,
    input  logic [POS_W-1:0]  end_position,
    input  logic [WORD_W-1:0] value,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] read_value,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  removed_count,
    output logic [CNT_W-1:0]  count_after
);

    // AW: RAM address, CW: count (0..CAPACITY), PW: common compare width
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // waiting for a request transfer
        S_SHIFT = 4'b0010,  // moving entries, one read and one write per cycle
        S_PUT   = 4'b0100,  // insert: place the new word at its rank
        S_DONE  = 4'b1000   // result ready, waiting for output register
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic            issue_reg;      // shift reads still to be issued
    logic            pend_reg;       // shift read in flight, write back this cycle
    logic            out_valid_reg;

    op_t             op_reg;
    status_t         status_reg;
    logic [AW-1:0]   pos_reg;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [CW-1:0]   n_reg;          // entries removed
    logic [AW-1:0]   ptr_reg;        // next shift read address
    logic [AW-1:0]   last_reg;       // final shift read address
    logic [AW-1:0]   pend_addr_reg;  // address of the read in flight

    logic [WORD_W-1:0] read_value_reg;
    status_t           status_out_reg;
    logic [CNT_W-1:0]  removed_reg;
    logic [CNT_W-1:0]  count_after_reg;

    // RAM port signals
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [ELEM_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [ELEM_WIDTH-1:0] ram_rd_data;

    logic    in_xfer;
    logic    out_free;
    op_t     dec_op;
    status_t dec_status;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] endp_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] hi_clip;
    logic [CW-1:0] n_calc;
    logic [CW-1:0] count_new;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    //------------------------------------------------------------------
    // Request decode: status, clipped range end, removed count
    //------------------------------------------------------------------
    always_comb
    begin
        dec_op   = op_t'(operation);
        pos_ext  = PW'(position);
        endp_ext = PW'(end_position);
        cnt_ext  = PW'(count_reg);
        hi_clip  = (endp_ext > cnt_ext) ? cnt_ext : endp_ext;
        n_calc   = CW'(hi_clip - pos_ext);
        case (dec_op)
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    dec_status = ST_RANGE;
                else if (count_reg == CW'(CAPACITY))
                    dec_status = ST_FULL;
                else
                    dec_status = ST_OK;
            end
            OP_REMOVE:
            begin
                if (endp_ext < pos_ext)
                    dec_status = ST_ORDER;
                else if (pos_ext > cnt_ext)
                    dec_status = ST_RANGE;
                else
                    dec_status = ST_OK;
            end
            default:
            begin
                dec_status = (pos_ext < cnt_ext) ? ST_OK : ST_RANGE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // RAM port muxing. Insert shifts downward (read i-1, write i) and
    // remove shifts upward (read i, write i-n), so the write, which follows
    // its read in the next cycle, never touches an address still to be read.
    //------------------------------------------------------------------
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = AW'(position);
                ram_wr_addr = AW'(position);
                ram_wr_data = ELEM_WIDTH'(value);
                ram_rd_en   = in_xfer && (dec_op == OP_READ) && (dec_status == ST_OK);
                ram_wr_en   = in_xfer && (dec_op == OP_WRITE) && (dec_status == ST_OK);
            end
            S_SHIFT:
            begin
                ram_rd_en   = issue_reg;
                ram_wr_en   = pend_reg;
                ram_wr_addr = (op_reg == OP_INSERT) ? (pend_addr_reg + AW'(1))
                                                    : (pend_addr_reg - AW'(n_reg));
            end
            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = val_reg;
            end
            S_DONE:
            begin
                ram_wr_en = 1'b0;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // count after a successful insert or remove
    always_comb
    begin
        count_new = count_reg;
        if (status_reg == ST_OK)
        begin
            if (op_reg == OP_INSERT)
                count_new = count_reg + CW'(1);
            else if (op_reg == OP_REMOVE)
                count_new = count_reg - n_reg;
        end
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_DONE;
                        if (dec_status == ST_OK && dec_op == OP_INSERT)
                        begin
                            if (cnt_ext > pos_ext)
                            begin
                                state_reg <= S_SHIFT;
                                issue_reg <= 1'b1;
                            end
                            else
                                state_reg <= S_PUT;
                        end
                        else if (dec_status == ST_OK && dec_op == OP_REMOVE &&
                                 n_calc != '0 && hi_clip < cnt_ext)
                        begin
                            state_reg <= S_SHIFT;
                            issue_reg <= 1'b1;
                        end
                    end
                end
                S_SHIFT:
                begin
                    pend_reg <= issue_reg;
                    if (issue_reg && ptr_reg == last_reg)
                        issue_reg <= 1'b0;
                    // last read went out last cycle; its write lands now
                    if (!issue_reg)
                        state_reg <= (op_reg == OP_INSERT) ? S_PUT : S_DONE;
                end
                S_PUT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        count_reg     <= count_new;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= dec_op;
            status_reg <= dec_status;
            pos_reg    <= AW'(position);
            val_reg    <= ELEM_WIDTH'(value);
            n_reg      <= n_calc;
            if (dec_op == OP_INSERT)
            begin
                ptr_reg  <= AW'(count_reg - CW'(1));
                last_reg <= AW'(position);
            end
            else
            begin
                ptr_reg  <= AW'(hi_clip);
                last_reg <= AW'(count_reg - CW'(1));
            end
        end
        else if (state_reg == S_SHIFT && issue_reg)
        begin
            pend_addr_reg <= ptr_reg;
            if (op_reg == OP_INSERT)
                ptr_reg <= ptr_reg - AW'(1);
            else
                ptr_reg <= ptr_reg + AW'(1);
        end

        if (state_reg == S_DONE && out_free)
        begin
            // read data stays in the RAM output register since the read
            read_value_reg  <= (op_reg == OP_READ && status_reg == ST_OK)
                               ? WORD_W'(ram_rd_data) : '0;
            status_out_reg  <= status_reg;
            removed_reg     <= (op_reg == OP_REMOVE && status_reg == ST_OK)
                               ? CNT_W'(n_reg) : '0;
            count_after_reg <= CNT_W'(count_new);
        end
    end

    rli_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign status        = status_out_reg;
    assign removed_count = removed_reg;
    assign count_after   = count_after_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // list never grows beyond capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // a result only appears after the sequencer finished an operation
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without completed operation");

    // once reads stop, the last one must still be writing back
    a_shift_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && !issue_reg) |-> pend_reg)
        else $error("shift ended without pending write");

    // no RAM activity while a result waits
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (!ram_wr_en && !ram_rd_en))
        else $error("RAM access in done state");

endmodule

// File: hdl/rli_ram.sv
module rli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rli_pkg::*;

    localparam int DEPTH            = CAPACITY_DEF;
    localparam int SCRIPT_LEN       = 26;
    localparam int RANDOM_ITEMS     = 361;
    localparam int CALM_ITEMS       = 60;   // tail of the run with no idling on either side
    localparam int LONG_HOLD_AT     = 150;  // random item index that triggers the long hold-off
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 80;   // exceeds the longest shift operation
    localparam int CYCLE_LIMIT      = 300000;

    // One request transfer: operation and its operands.
    typedef struct {
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  end_pos;
        logic [WORD_W-1:0] val;
    } list_request_t;

    // One result transfer.
    typedef struct {
        logic [WORD_W-1:0] read_value;
        status_t           st;
        logic [CNT_W-1:0]  removed;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    // Directed script row. reps > 1 repeats the row with value ^ rep index.
    // typed rows carry their own expected result (read_value is zero there);
    // the rest take the prediction.
    typedef struct {
        op_t         op;
        int          pos;
        int          end_pos;
        logic [31:0] val;
        int          reps;
        bit          typed;
        status_t     st;
        int          removed;
        int          count;
    } script_row_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   operation    = OP_READ;
    logic [POS_W-1:0]  position     = '0;
    logic [POS_W-1:0]  end_position = '0;
    logic [WORD_W-1:0] value        = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  count_after;

    // Shadow copy of the list, advanced once per accepted request.
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_count = 0;

    // Results still owed by the block, oldest first.
    list_result_t      owed_results [$];

    int  error_count    = 0;
    int  results_seen   = 0;
    int  cycle_count    = 0;
    bit  calm           = 1'b0;
    bit  long_hold_req  = 1'b0;
    bit  long_hold_done = 1'b0;

    // Directed part: empty-list refusals, ordering and range errors, end inserts,
    // clipping of the remove end, then a fill to capacity and full-store refusals.
    script_row_t script [SCRIPT_LEN] = '{
        // empty list: every access refused or a no-op
        '{OP_READ,    0,  0, 32'h0000_0000,  1, 1'b1, ST_RANGE, 0,  0},
        '{OP_WRITE,   0,  0, 32'hDEAD_BEEF,  1, 1'b1, ST_RANGE, 0,  0},
        '{OP_REMOVE,  0,  0, 32'h0000_0000,  1, 1'b1, ST_OK,    0,  0},
        '{OP_REMOVE,  5,  2, 32'h0000_0000,  1, 1'b1, ST_ORDER, 0,  0},
        '{OP_REMOVE,  1, 64, 32'h0000_0000,  1, 1'b1, ST_RANGE, 0,  0},
        '{OP_INSERT,  1,  0, 32'h1111_1111,  1, 1'b1, ST_RANGE, 0,  0},
        // build a short list: head, head again, append, middle
        '{OP_INSERT,  0,  0, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,    0,  1},
        '{OP_INSERT,  0,  0, 32'h0000_0000,  1, 1'b1, ST_OK,    0,  2},
        '{OP_INSERT,  2,  0, 32'hA5A5_5A5A,  1, 1'b1, ST_OK,    0,  3},
        '{OP_INSERT,  1,  0, 32'h1234_5678,  1, 1'b0, ST_OK,    0,  0},
        '{OP_READ,    3,  0, 32'h0000_0000,  1, 1'b0, ST_OK,    0,  0},
        '{OP_WRITE,   3,  0, 32'h8000_0001,  1, 1'b0, ST_OK,    0,  0},
        '{OP_READ,    3,  0, 32'h0000_0000,  1, 1'b0, ST_OK,    0,  0},
        '{OP_READ,    4,  0, 32'h0000_0000,  1, 1'b1, ST_RANGE, 0,  4},
        '{OP_WRITE,   4,  0, 32'h5555_AAAA,  1, 1'b1, ST_RANGE, 0,  4},
        '{OP_REMOVE,  1,  3, 32'h0000_0000,  1, 1'b1, ST_OK,    2,  2},
        // end past the count is clipped
        '{OP_REMOVE,  0, 64, 32'h0000_0000,  1, 1'b1, ST_OK,    2,  0},
        // fill to capacity, inserting at the head each time (longest shifts)
        '{OP_INSERT,  0,  0, 32'hC000_0000, 64, 1'b0, ST_OK,    0,  0},
        '{OP_INSERT, 64,  0, 32'h0BAD_0BAD,  1, 1'b1, ST_FULL,  0, 64},
        '{OP_WRITE,  63,  0, 32'h7FFF_FFFF,  1, 1'b0, ST_OK,    0,  0},
        '{OP_READ,   63,  0, 32'h0000_0000,  1, 1'b0, ST_OK,    0,  0},
        '{OP_READ,   64,  0, 32'h0000_0000,  1, 1'b1, ST_RANGE, 0, 64},
        '{OP_REMOVE, 64, 64, 32'h0000_0000,  1, 1'b1, ST_OK,    0, 64},
        '{OP_REMOVE,  0,  1, 32'h0000_0000,  1, 1'b1, ST_OK,    1, 63},
        '{OP_INSERT, 63,  0, 32'h0F0F_F0F0,  1, 1'b1, ST_OK,    0, 64},
        '{OP_REMOVE,  0, 64, 32'h0000_0000,  1, 1'b1, ST_OK,   64,  0}
    };

    ranked_list_insert_remove_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .position      (position),
        .end_position  (end_position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .removed_count (removed_count),
        .count_after   (count_after)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one request to the shadow list and returns the result it owes.
    function automatic list_result_t apply_list_op(input list_request_t r);
        list_result_t res;
        int           lo;
        int           hi;
        int           n;
        int           i;
        lo             = int'(r.pos);
        hi             = int'(r.end_pos);
        res.read_value = '0;
        res.st         = ST_OK;
        res.removed    = '0;
        case (r.op)
            OP_INSERT:
            begin
                // rank is checked before capacity
                if (lo > list_count)
                    res.st = ST_RANGE;
                else if (list_count >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    for (i = list_count; i > lo; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[lo] = r.val;
                    list_count++;
                end
            end
            OP_REMOVE:
            begin
                // order check first, then start rank, then clip the end
                if (hi < lo)
                    res.st = ST_ORDER;
                else if (lo > list_count)
                    res.st = ST_RANGE;
                else
                begin
                    if (hi > list_count)
                        hi = list_count;
                    n = hi - lo;
                    for (i = hi; i < list_count; i++)
                        list_words[i - n] = list_words[i];
                    list_count -= n;
                    res.removed = CNT_W'(n);
                end
            end
            OP_READ:
            begin
                if (lo < list_count)
                    res.read_value = list_words[lo];
                else
                    res.st = ST_RANGE;
            end
            default:
            begin
                if (lo < list_count)
                    list_words[lo] = r.val;
                else
                    res.st = ST_RANGE;
            end
        endcase
        res.count = CNT_W'(list_count);
        return res;
    endfunction

    // Random request shaped by the current list size. grow biases toward inserts
    // so the list climbs toward capacity; otherwise removes with wider ranges
    // pull it back down. About one in ten ranks, and one in ten remove ends, are
    // taken anywhere in 0 to DEPTH to hit the refusals.
    function automatic list_request_t make_list_request(input bit grow);
        list_request_t r;
        int            pick;
        int            span;
        int            stop;
        pick = $urandom_range(0, 99);
        if (pick < (grow ? 50 : 22))
            r.op = OP_INSERT;
        else if (pick < (grow ? 58 : 50))
            r.op = OP_REMOVE;
        else if (pick < 78)
            r.op = OP_READ;
        else
            r.op = OP_WRITE;

        r.val = $urandom;
        case ($urandom_range(0, 7))
            0:       r.val = '0;
            1:       r.val = '1;
            default: ;
        endcase

        if ($urandom_range(0, 9) == 0)
            r.pos = POS_W'($urandom_range(0, DEPTH));
        else if ((r.op inside {OP_READ, OP_WRITE}) && list_count > 0)
            r.pos = POS_W'($urandom_range(0, list_count - 1));
        else
            r.pos = POS_W'($urandom_range(0, list_count));

        r.end_pos = POS_W'($urandom_range(0, DEPTH));
        if (r.op == OP_REMOVE && $urandom_range(0, 9) != 0)
        begin
            span      = grow ? $urandom_range(0, 3) : $urandom_range(0, 12);
            stop      = int'(r.pos) + span;
            r.end_pos = POS_W'((stop > DEPTH) ? DEPTH : stop);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                 $time, results_seen, field, got, want);
    endtask

    // Random idle burst on the request side; none in the calm tail.
    task automatic request_gap();
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Offers one request and holds it until the transfer happens, then books
    // the owed result. Called at a rising edge; returns at the accepting edge.
    task automatic offer_request(input list_request_t r, input bit use_fixed,
                                 input list_result_t fixed);
        list_result_t owed;
        operation    <= r.op;
        position     <= r.pos;
        end_position <= r.end_pos;
        value        <= r.val;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        owed = apply_list_op(r);
        if (use_fixed)
            owed = fixed;
        owed_results.push_back(owed);
    endtask

    // Request side: reset, directed script, random traffic, drain, verdict.
    initial
    begin : request_source
        list_request_t req;
        list_result_t  fixed;
        int            k;
        int            rep;
        bit            grow;

        grow = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            for (rep = 0; rep < script[i].reps; rep++)
            begin
                req.op           = script[i].op;
                req.pos          = POS_W'(script[i].pos);
                req.end_pos      = POS_W'(script[i].end_pos);
                req.val          = script[i].val ^ rep;
                fixed.read_value = '0;
                fixed.st         = script[i].st;
                fixed.removed    = CNT_W'(script[i].removed);
                fixed.count      = CNT_W'(script[i].count);
                request_gap();
                offer_request(req, script[i].typed, fixed);
            end
        end

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // the growth bias is redrawn every 60 requests, grow two times in three,
            // so the list swings between near-empty and near-full
            if (k % 60 == 0)
                grow = ($urandom_range(0, 2) != 0);
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            if (k == LONG_HOLD_AT)
                long_hold_req = 1'b1;
            req = make_list_request(grow);
            request_gap();
            offer_request(req, 1'b0, fixed);
        end
        in_valid <= 1'b0;

        // wait for every owed result, then watch for strays
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side back-pressure: random stall bursts and free-running stretches,
    // plus one long hold-off so the block backs up and stalls its input while
    // the request side keeps offering.
    initial
    begin : result_sink
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Checks each result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        list_result_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch("unowed result, count_after", 32'(count_after), '0);
            else
            begin
                owed = owed_results.pop_front();
                if (read_value !== owed.read_value)
                    report_mismatch("read_value", read_value, owed.read_value);
                if (status !== owed.st)
                    report_mismatch("status", 32'(status), 32'(owed.st));
                if (removed_count !== owed.removed)
                    report_mismatch("removed_count", 32'(removed_count),
                                    32'(owed.removed));
                if (count_after !== owed.count)
                    report_mismatch("count_after", 32'(count_after), 32'(owed.count));
            end
            results_seen++;
        end
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed",
                     cycle_count, owed_results.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
